FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker of the hash block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define XXH_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hash block assertion failed");

// Next-cycle implication, switched off while reset is high.
`define XXH_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hash block assertion failed");

// Next-cycle implication that also holds through reset.
`define XXH_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("hash block assertion failed");

`endif

FILE: rtl/core/xxh_pkg.sv
// Shared types, constants and helpers of the byte-serial hash block.
package xxh_pkg;

   // Hash primes and start values
   localparam logic [31:0] PRIME_A     = 32'h9E3779B1;
   localparam logic [31:0] PRIME_B     = 32'h85EBCA77;
   localparam logic [31:0] PRIME_C     = 32'hC2B2AE3D;
   localparam logic [31:0] PRIME_D     = 32'h27D4EB2F;
   localparam logic [31:0] PRIME_E     = 32'h165667B1;
   localparam logic [31:0] SHORT_START = 32'h178A54A4;

   localparam logic [31:0] LANE_INIT_0 = 32'h2557311B;
   localparam logic [31:0] LANE_INIT_1 = 32'h871FB76A;
   localparam logic [31:0] LANE_INIT_2 = 32'h0133ECF3;
   localparam logic [31:0] LANE_INIT_3 = 32'h62FC7342;

   // Depth of the request queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Request kinds after classification
   typedef enum logic [1:0] {
      OP_BYTE,
      OP_LAST_BYTE,
      OP_END
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Back-end sequencer states
   typedef enum logic [3:0] {
      ST_RUN,
      ST_DRAIN,
      ST_SUM,
      ST_TAIL,
      ST_W_MUL,
      ST_W_ADD,
      ST_W_FIN,
      ST_B_MUL,
      ST_B_ADD,
      ST_B_FIN,
      ST_AV1,
      ST_AV2,
      ST_AV3
   } back_state_type;

   // Phases of one lane round in the stripe fold
   typedef enum logic [1:0] {
      FP_MUL_W,
      FP_ADD,
      FP_MUL_P
   } fold_phase_type;

   // Rotate left; always called with a constant amount
   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
      return (v << n) | (v >> (6'd32 - {1'b0, n}));
   endfunction

   // Lane start value after reset or after a digest
   function automatic logic [31:0] lane_init(input logic [1:0] k);
      logic [31:0] v;
      unique case (k)
         2'd0:    v = LANE_INIT_0;
         2'd1:    v = LANE_INIT_1;
         2'd2:    v = LANE_INIT_2;
         default: v = LANE_INIT_3;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/core/xxh_front.sv
// Front end: takes requests, drops idle ones and classifies the rest for the queue.
module xxh_front (
   input  logic                 req_valid,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_has_byte,
   input  logic                 req_last_byte,
   output logic                 req_stall,
   input  xxh_pkg::q_status_type q_status,
   output logic                 push,
   output xxh_pkg::q_entry_type push_entry
);

   // Stall only on a full queue, so stall never looks at valid
   always_comb begin
      req_stall       = q_status.full;
      push            = req_valid && !q_status.full && (req_has_byte || req_last_byte);
      push_entry.data = req_data_byte;
      unique case ({req_has_byte, req_last_byte})
         2'b11:   push_entry.op = xxh_pkg::OP_LAST_BYTE;
         2'b10:   push_entry.op = xxh_pkg::OP_BYTE;
         default: push_entry.op = xxh_pkg::OP_END;
      endcase
   end

endmodule

FILE: rtl/core/xxh_queue.sv
// Small request queue that decouples the front end from the hash back end.
module xxh_queue #(
   parameter int DEPTH = xxh_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  xxh_pkg::q_entry_type  push_entry,
   input  logic                  pop,
   output xxh_pkg::q_entry_type  head,
   output xxh_pkg::q_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   xxh_pkg::q_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued requests
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

FILE: rtl/core/xxh_back.sv
// Back end: byte buffer, background stripe fold into four lanes, and digest sequencer.
module xxh_back (
   input  logic                  clock,
   input  logic                  reset,
   input  xxh_pkg::q_entry_type  head,
   input  xxh_pkg::q_status_type q_status,
   output logic                  pop,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [31:0]           rsp_digest
);

   xxh_pkg::back_state_type state_ff, state_in;
   xxh_pkg::fold_phase_type fold_ph_ff, fold_ph_in;

   logic [127:0] buf_ff,    buf_in;
   logic [127:0] stripe_ff, stripe_in;
   logic [4:0]   fill_ff,   fill_in;
   logic [31:0]  len_ff,    len_in;
   logic         taken_ff,  taken_in;
   logic [31:0]  lane_ff [4];
   logic [31:0]  lane_in [4];
   logic [31:0]  h_ff,      h_in;
   logic [31:0]  tmp_ff,    tmp_in;
   logic [1:0]   sum_idx_ff, sum_idx_in;
   logic         fold_busy_ff, fold_busy_in;
   logic [1:0]   fold_k_ff, fold_k_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [31:0]  rsp_digest_ff, rsp_digest_in;

   logic [31:0]  mul_a, mul_b, mul_p;
   logic [1:0]   lane_sel;
   logic [31:0]  lane_rd;
   logic [31:0]  stripe_word;
   logic [31:0]  sum_rot;
   logic         is_byte;

   // One lane read port, shared by the fold and the lane sum
   assign lane_sel    = fold_busy_ff ? fold_k_ff : sum_idx_ff;
   assign lane_rd     = lane_ff[lane_sel];
   assign stripe_word = stripe_ff[{fold_k_ff, 5'd0} +: 32];
   assign is_byte     = (head.op != xxh_pkg::OP_END);

   // Pick the rotated lane for the digest sum
   always_comb begin
      case (sum_idx_ff)
         2'd0:    sum_rot = xxh_pkg::rotl32(lane_rd, 5'd1);
         2'd1:    sum_rot = xxh_pkg::rotl32(lane_rd, 5'd7);
         2'd2:    sum_rot = xxh_pkg::rotl32(lane_rd, 5'd12);
         default: sum_rot = xxh_pkg::rotl32(lane_rd, 5'd18);
      endcase
   end

   // Shared multiplier: the fold owns it while busy, the digest steps otherwise
   always_comb begin
      mul_a = tmp_ff;
      mul_b = xxh_pkg::PRIME_A;
      if (fold_busy_ff) begin
         if (fold_ph_ff == xxh_pkg::FP_MUL_W) begin
            mul_a = stripe_word;
            mul_b = xxh_pkg::PRIME_B;
         end
      end else begin
         case (state_ff)
            xxh_pkg::ST_W_MUL: begin
               mul_a = buf_ff[31:0];
               mul_b = xxh_pkg::PRIME_C;
            end
            xxh_pkg::ST_W_FIN: begin
               mul_b = xxh_pkg::PRIME_D;
            end
            xxh_pkg::ST_B_MUL: begin
               mul_a = {24'd0, buf_ff[7:0]};
               mul_b = xxh_pkg::PRIME_E;
            end
            xxh_pkg::ST_AV1: begin
               mul_a = h_ff ^ (h_ff >> 15);
               mul_b = xxh_pkg::PRIME_B;
            end
            xxh_pkg::ST_AV2: begin
               mul_a = h_ff ^ (h_ff >> 13);
               mul_b = xxh_pkg::PRIME_C;
            end
            default: begin
               mul_a = tmp_ff;
               mul_b = xxh_pkg::PRIME_A;
            end
         endcase
      end
   end

   // Keep the low word of the 32x32 product
   assign mul_p = mul_a * mul_b;

   // Fold sequencer and digest sequencer
   always_comb begin
      state_in      = state_ff;
      fold_ph_in    = fold_ph_ff;
      buf_in        = buf_ff;
      stripe_in     = stripe_ff;
      fill_in       = fill_ff;
      len_in        = len_ff;
      taken_in      = taken_ff;
      lane_in       = lane_ff;
      h_in          = h_ff;
      tmp_in        = tmp_ff;
      sum_idx_in    = sum_idx_ff;
      fold_busy_in  = fold_busy_ff;
      fold_k_in     = fold_k_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_digest_in = rsp_digest_ff;
      pop           = 1'b0;

      // Fold one lane in three steps: multiply word, add and rotate, multiply
      if (fold_busy_ff) begin
         unique case (fold_ph_ff)
            xxh_pkg::FP_MUL_W: begin
               tmp_in     = mul_p;
               fold_ph_in = xxh_pkg::FP_ADD;
            end
            xxh_pkg::FP_ADD: begin
               tmp_in     = xxh_pkg::rotl32(lane_rd + tmp_ff, 5'd13);
               fold_ph_in = xxh_pkg::FP_MUL_P;
            end
            xxh_pkg::FP_MUL_P: begin
               lane_in[fold_k_ff] = mul_p;
               fold_ph_in         = xxh_pkg::FP_MUL_W;
               fold_k_in          = fold_k_ff + 2'd1;
               if (fold_k_ff == 2'd3) begin
                  fold_busy_in = 1'b0;
               end
            end
            default: begin
               fold_ph_in = xxh_pkg::FP_MUL_W;
            end
         endcase
      end

      unique case (state_ff)
         // Take bytes; a full buffer moves to the fold when one more byte comes
         xxh_pkg::ST_RUN: begin
            if (!q_status.empty && !(is_byte && fill_ff[4] && fold_busy_ff)) begin
               pop = 1'b1;
               if (is_byte) begin
                  if (fill_ff[4]) begin
                     stripe_in    = buf_ff;
                     fold_busy_in = 1'b1;
                     fold_k_in    = 2'd0;
                     fold_ph_in   = xxh_pkg::FP_MUL_W;
                     taken_in     = 1'b1;
                     fill_in      = 5'd1;
                  end else begin
                     fill_in = fill_ff + 5'd1;
                  end
                  buf_in[{fill_ff[3:0], 3'd0} +: 8] = head.data;
                  len_in = len_ff + 32'd1;
               end
               if (head.op != xxh_pkg::OP_BYTE) begin
                  state_in = xxh_pkg::ST_DRAIN;
               end
            end
         end
         // Wait for the fold; fold the first stripe if none went in yet
         xxh_pkg::ST_DRAIN: begin
            if (!fold_busy_ff) begin
               if (!taken_ff && fill_ff[4]) begin
                  stripe_in    = buf_ff;
                  fold_busy_in = 1'b1;
                  fold_k_in    = 2'd0;
                  fold_ph_in   = xxh_pkg::FP_MUL_W;
                  taken_in     = 1'b1;
                  fill_in      = 5'd0;
               end else begin
                  h_in       = len_ff + (taken_ff ? 32'd0 : xxh_pkg::SHORT_START);
                  sum_idx_in = 2'd0;
                  state_in   = taken_ff ? xxh_pkg::ST_SUM : xxh_pkg::ST_TAIL;
               end
            end
         end
         // Add the rotated lanes, one a cycle
         xxh_pkg::ST_SUM: begin
            h_in       = h_ff + sum_rot;
            sum_idx_in = sum_idx_ff + 2'd1;
            if (sum_idx_ff == 2'd3) begin
               state_in = xxh_pkg::ST_TAIL;
            end
         end
         // Choose word round, byte round or avalanche
         xxh_pkg::ST_TAIL: begin
            if (fill_ff >= 5'd4) begin
               state_in = xxh_pkg::ST_W_MUL;
            end else if (fill_ff != 5'd0) begin
               state_in = xxh_pkg::ST_B_MUL;
            end else begin
               state_in = xxh_pkg::ST_AV1;
            end
         end
         xxh_pkg::ST_W_MUL: begin
            tmp_in   = mul_p;
            state_in = xxh_pkg::ST_W_ADD;
         end
         xxh_pkg::ST_W_ADD: begin
            tmp_in   = xxh_pkg::rotl32(h_ff + tmp_ff, 5'd17);
            state_in = xxh_pkg::ST_W_FIN;
         end
         xxh_pkg::ST_W_FIN: begin
            h_in     = mul_p;
            buf_in   = buf_ff >> 32;
            fill_in  = fill_ff - 5'd4;
            state_in = xxh_pkg::ST_TAIL;
         end
         xxh_pkg::ST_B_MUL: begin
            tmp_in   = mul_p;
            state_in = xxh_pkg::ST_B_ADD;
         end
         xxh_pkg::ST_B_ADD: begin
            tmp_in   = xxh_pkg::rotl32(h_ff + tmp_ff, 5'd11);
            state_in = xxh_pkg::ST_B_FIN;
         end
         xxh_pkg::ST_B_FIN: begin
            h_in     = mul_p;
            buf_in   = buf_ff >> 8;
            fill_in  = fill_ff - 5'd1;
            state_in = xxh_pkg::ST_TAIL;
         end
         xxh_pkg::ST_AV1: begin
            h_in     = mul_p;
            state_in = xxh_pkg::ST_AV2;
         end
         xxh_pkg::ST_AV2: begin
            h_in     = mul_p;
            state_in = xxh_pkg::ST_AV3;
         end
         // Hand the digest to the output register and restart the message state
         xxh_pkg::ST_AV3: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_digest_in = h_ff ^ (h_ff >> 16);
               lane_in[0]    = xxh_pkg::lane_init(2'd0);
               lane_in[1]    = xxh_pkg::lane_init(2'd1);
               lane_in[2]    = xxh_pkg::lane_init(2'd2);
               lane_in[3]    = xxh_pkg::lane_init(2'd3);
               fill_in       = 5'd0;
               len_in        = 32'd0;
               taken_in      = 1'b0;
               state_in      = xxh_pkg::ST_RUN;
            end
         end
         default: begin
            state_in = xxh_pkg::ST_RUN;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xxh_pkg::ST_RUN;
         fold_ph_ff   <= xxh_pkg::FP_MUL_W;
         fill_ff      <= 5'd0;
         len_ff       <= 32'd0;
         taken_ff     <= 1'b0;
         lane_ff[0]   <= xxh_pkg::lane_init(2'd0);
         lane_ff[1]   <= xxh_pkg::lane_init(2'd1);
         lane_ff[2]   <= xxh_pkg::lane_init(2'd2);
         lane_ff[3]   <= xxh_pkg::lane_init(2'd3);
         sum_idx_ff   <= 2'd0;
         fold_busy_ff <= 1'b0;
         fold_k_ff    <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fold_ph_ff   <= fold_ph_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         taken_ff     <= taken_in;
         lane_ff      <= lane_in;
         sum_idx_ff   <= sum_idx_in;
         fold_busy_ff <= fold_busy_in;
         fold_k_ff    <= fold_k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Data path registers
   always_ff @(posedge clock) begin
      buf_ff        <= buf_in;
      stripe_ff     <= stripe_in;
      h_ff          <= h_in;
      tmp_ff        <= tmp_in;
      rsp_digest_ff <= rsp_digest_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_digest = rsp_digest_ff;

endmodule

FILE: rtl/core/xxhash32_custom_stream_top.sv
// Byte-serial 32-bit hash with fixed seed: front end, request queue and back end.
//
// Requests carry one message byte (req_data_byte, req_has_byte) and an end
// flag (req_last_byte); a request with req_has_byte low and req_last_byte low
// is dropped, one with req_has_byte low and req_last_byte high ends the
// message with the bytes seen so far. One response with rsp_digest follows
// each request that has req_last_byte set. A transfer completes on a clock
// edge with valid high and stall low on that channel.
// Throughput: one byte a cycle inside a message, except that a byte arriving on a
// full buffer waits while the lane fold is busy. Each such byte hands the buffered
// 16-byte stripe to the lane fold, which runs in the background on the shared
// 32x32 multiplier. The time until rsp_valid rises after the last request is
// taken is set by the fold still in flight, the lane sum, the word or byte
// rounds of the tail (at most six rounds) and the avalanche; the multiply steps
// among these share that one multiplier.
// Reset (synchronous, active high) empties the queue, drops any message in
// progress and clears rsp_valid. A stalled response holds in the output
// register; the back end finishes the next digest and then waits, while the
// queue fills and raises req_stall when full.
module xxhash32_custom_stream_top #(
   parameter int QUEUE_DEPTH = xxh_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest
);

   xxh_pkg::q_status_type q_status;
   xxh_pkg::q_entry_type  push_entry;
   xxh_pkg::q_entry_type  head;
   logic                  push;
   logic                  pop;

   xxh_front u_front (
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_has_byte  (req_has_byte),
      .req_last_byte (req_last_byte),
      .req_stall     (req_stall),
      .q_status      (q_status),
      .push          (push),
      .push_entry    (push_entry)
   );

   xxh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   xxh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_digest (rsp_digest)
   );

endmodule

FILE: rtl/core/xxh_checker.sv
// Port-level checker for the hash block, bound to the top level.
`include "assert_macros.svh"

module xxh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_digest
);

   logic [3:0] pend_ff, pend_in;
   logic       end_acc;
   logic       rsp_acc;

   // Track ended messages whose digest is not yet taken
   assign end_acc = req_valid && !req_stall && req_last_byte;
   assign rsp_acc = rsp_valid && !rsp_stall;
   assign pend_in = pend_ff + {3'd0, end_acc} - {3'd0, rsp_acc};

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 4'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `XXH_ASSERT_NXT_ALWAYS(a_reset_clears_rsp, clock, reset, !rsp_valid)
   `XXH_ASSERT_NXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_digest))
   `XXH_ASSERT_IMP(a_rsp_needs_end, clock, reset, rsp_valid, pend_ff != 4'd0)

endmodule

bind xxhash32_custom_stream_top xxh_checker u_xxh_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_last_byte (req_last_byte),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_digest    (rsp_digest)
);
